// ===== design/lwc_pkg.sv =====
// Shared types, codes and helpers for the LRU write-back cache model.
package lwc_pkg;

  localparam int CTR_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [2:0] LINE_LOG2_MIN   = 3'd4;
  localparam logic [2:0] SIZE_LOG2_MAX   = 3'd4;
  localparam logic [2:0] LINE_LOG2_RESET = 3'd5;
  localparam logic [3:0] SET_LOG2_RESET  = 4'd7;
  localparam logic [2:0] WAY_COUNT_RESET = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LOG2 = 2'd0,
    CFG_SET_LOG2  = 2'd1,
    CFG_WAY_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_READ  = 4'b1000
  } state_e;

  typedef struct packed {
    logic hit;
    logic wrote_back;
  } lookup_flags_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/lwc_way_logic.sv =====
// Set row update: hit search, victim choice, LRU rank update and fill.
module lwc_way_logic
  import lwc_pkg::*;
#(
  parameter int MAX_WAYS = 4,
  parameter int TAG_W    = 28,
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int NW_W    = $clog2(MAX_WAYS + 1)
) (
  input  logic [TAG_W-1:0]                  la_i,
  input  logic                              st_i,
  input  logic [NW_W-1:0]                   ways_i,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]    tag_i,
  input  logic [MAX_WAYS-1:0]               valid_i,
  input  logic [MAX_WAYS-1:0]               dirty_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]   rank_i,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]    tag_o,
  output logic [MAX_WAYS-1:0]               valid_o,
  output logic [MAX_WAYS-1:0]               dirty_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]   rank_o,
  output lookup_flags_t                     flags_o,
  output logic [RANK_W-1:0]                 way_o
);

  always_comb begin
    logic              hit;
    logic [RANK_W-1:0] hit_way;
    logic              inv;
    logic [RANK_W-1:0] inv_way;
    logic [RANK_W-1:0] lru_way;
    logic [RANK_W-1:0] way;
    logic [RANK_W-1:0] old;

    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((NW_W'(w) < ways_i) && valid_i[w] && (tag_i[w] == la_i)) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
    end

    inv     = 1'b0;
    inv_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if ((NW_W'(w) < ways_i) && !valid_i[w]) begin
        inv     = 1'b1;
        inv_way = RANK_W'(w);
      end
    end

    // ties keep the lower way
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((NW_W'(w) < ways_i) && (rank_i[w] > rank_i[lru_way])) begin
        lru_way = RANK_W'(w);
      end
    end

    way = hit ? hit_way : (inv ? inv_way : lru_way);
    old = valid_i[way] ? rank_i[way] : RANK_W'(MAX_WAYS - 1);

    flags_o.hit        = hit;
    flags_o.wrote_back = !hit && valid_i[way] && dirty_i[way];
    way_o              = way;

    tag_o   = tag_i;
    valid_o = valid_i;
    dirty_o = dirty_i;
    rank_o  = rank_i;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if ((NW_W'(v) < ways_i) && (RANK_W'(v) != way) && valid_i[v] && (rank_i[v] < old)) begin
        rank_o[v] = rank_i[v] + 1'b1;
      end
    end
    rank_o[way] = '0;
    if (hit) begin
      dirty_o[way] = dirty_i[way] | st_i;
    end else begin
      valid_o[way] = 1'b1;
      dirty_o[way] = st_i;
      tag_o[way]   = la_i;
    end
  end

endmodule

// ===== design/lru_writeback_cache_model.sv =====
// Tag-only set-associative write-back cache model with LRU replacement.
// An accepted access reads its set row and the lookup state writes the row back and
// registers the result strobe; a line-crossing access repeats this for its second line.
// Each lookup is a read-modify-write of one row of the set memory; no access is taken while busy.
// Reset: a clearing sweep writes every set row, 2^floor(log2 MAX_SETS) rows (512 by
// default), with busy high; config writes are taken at any time. The receiver cannot stall.
module lru_writeback_cache_model
  import lwc_pkg::*;
#(
  parameter int MAX_SETS  = 512,
  parameter int MAX_WAYS  = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [ADDR_BITS-1:0]   address_i,
  input  logic [2:0]             size_log2_i,
  input  logic                   store_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic                   hit_o,
  output logic                   wrote_back_o,
  output logic [1:0]             way_used_o,
  output logic [CTR_W-1:0]       access_total_o,
  output logic [CTR_W-1:0]       miss_total_o,
  output logic [CTR_W-1:0]       writeback_total_o,
  output logic                   last_o
);

  localparam int SET_LOG2_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int DEPTH        = 1 << SET_LOG2_MAX;
  localparam int SIDX_W       = (SET_LOG2_MAX > 0) ? SET_LOG2_MAX : 1;
  localparam int TAG_W        = ADDR_BITS - 4;
  localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W         = $clog2(MAX_WAYS + 1);
  localparam int ROW_W        = MAX_WAYS * (TAG_W + 2 + RANK_W);

  state_e state_q, state_d;

  logic [2:0] line_log2_q;
  logic [3:0] set_log2_q;
  logic [2:0] way_count_q;

  logic [SIDX_W-1:0] clr_q;
  logic              two_q, phase_q;
  logic              st_q;
  logic [TAG_W-1:0]  la1_q, la2_q;

  logic [CTR_W-1:0] acc_q, miss_q, wb_q;
  logic             done_q, hit_q, wrote_back_q, last_q;
  logic [RANK_W-1:0] way_q;

  // config
  logic [2:0]        line_eff;
  logic [SIDX_W-1:0] set_mask;
  logic [NW_W-1:0]   ways_eff;

  assign line_eff = (line_log2_q < LINE_LOG2_MIN) ? LINE_LOG2_MIN : line_log2_q;

  always_comb begin
    for (int i = 0; i < SIDX_W; i++) begin
      set_mask[i] = (i < SET_LOG2_MAX) && (i < set_log2_q);
    end
  end

  always_comb begin
    if (way_count_q == 3'd0) begin
      ways_eff = NW_W'(1);
    end else if (int'(way_count_q) > MAX_WAYS) begin
      ways_eff = NW_W'(MAX_WAYS);
    end else begin
      ways_eff = NW_W'(way_count_q);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_log2_q <= LINE_LOG2_RESET;
      set_log2_q  <= SET_LOG2_RESET;
      way_count_q <= WAY_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LINE_LOG2: line_log2_q <= cfg_data_i[2:0];
        CFG_SET_LOG2:  set_log2_q  <= cfg_data_i;
        CFG_WAY_COUNT: way_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // access split into line addresses
  logic [2:0]           size_eff;
  logic [4:0]           span;
  logic [ADDR_BITS-1:0] last_addr;
  logic [TAG_W-1:0]     la1_in, la2_in;
  logic                 accept;

  assign size_eff  = (size_log2_i > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : size_log2_i;
  assign span      = 5'((6'd1 << size_eff) - 6'd1);
  assign last_addr = address_i + ADDR_BITS'(span);
  assign la1_in    = TAG_W'(address_i >> line_eff);
  assign la2_in    = TAG_W'(last_addr >> line_eff);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);

  // set memory
  logic [ROW_W-1:0]  mem_q [DEPTH];
  logic [ROW_W-1:0]  rdata_q, wdata;
  logic              mem_we, mem_re;
  logic [SIDX_W-1:0] raddr, waddr;
  logic [TAG_W-1:0]  la_cur;

  assign la_cur = phase_q ? la2_q : la1_q;
  assign mem_re = accept || (state_q == ST_READ);
  assign raddr  = (state_q == ST_READ) ? (la2_q[SIDX_W-1:0] & set_mask)
                                       : (la1_in[SIDX_W-1:0] & set_mask);
  assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_LOOK);
  assign waddr  = (state_q == ST_CLEAR) ? clr_q : (la_cur[SIDX_W-1:0] & set_mask);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag, nx_tag;
  logic [MAX_WAYS-1:0]             rd_valid, nx_valid;
  logic [MAX_WAYS-1:0]             rd_dirty, nx_dirty;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank, nx_rank;
  lookup_flags_t                   flags;
  logic [RANK_W-1:0]               way;

  assign {rd_tag, rd_valid, rd_dirty, rd_rank} = rdata_q;
  assign wdata = (state_q == ST_CLEAR) ? '0 : {nx_tag, nx_valid, nx_dirty, nx_rank};

  lwc_way_logic #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W)
  ) u_way_logic (
    .la_i    (la_cur),
    .st_i    (st_q),
    .ways_i  (ways_eff),
    .tag_i   (rd_tag),
    .valid_i (rd_valid),
    .dirty_i (rd_dirty),
    .rank_i  (rd_rank),
    .tag_o   (nx_tag),
    .valid_o (nx_valid),
    .dirty_o (nx_dirty),
    .rank_o  (nx_rank),
    .flags_o (flags),
    .way_o   (way)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SIDX_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_LOOK;
      ST_LOOK:  state_d = (two_q && !phase_q) ? ST_READ : ST_IDLE;
      ST_READ:  state_d = ST_LOOK;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      two_q        <= 1'b0;
      phase_q      <= 1'b0;
      acc_q        <= '0;
      miss_q       <= '0;
      wb_q         <= '0;
      done_q       <= 1'b0;
      hit_q        <= 1'b0;
      wrote_back_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_LOOK);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        two_q   <= (la1_in != la2_in);
        phase_q <= 1'b0;
      end
      if (state_q == ST_READ) begin
        phase_q <= 1'b1;
      end
      if (state_q == ST_LOOK) begin
        acc_q <= sat_inc(acc_q);
        if (!flags.hit) begin
          miss_q <= sat_inc(miss_q);
        end
        if (flags.wrote_back) begin
          wb_q <= sat_inc(wb_q);
        end
        hit_q        <= flags.hit;
        wrote_back_q <= flags.wrote_back;
        last_q       <= phase_q || !two_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      la1_q <= la1_in;
      la2_q <= la2_in;
      st_q  <= store_i;
    end
    if (state_q == ST_LOOK) begin
      way_q <= way;
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign wrote_back_o      = wrote_back_q;
  assign way_used_o        = 2'(way_q);
  assign access_total_o    = acc_q;
  assign miss_total_o      = miss_q;
  assign writeback_total_o = wb_q;
  assign last_o            = last_q;

`ifndef SYNTHESIS
  a_done_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_LOOK))
    else $error("result strobe without a lookup");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("set memory read and write in the same cycle");

  a_wb_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && wrote_back_o) |-> !hit_o)
    else $error("writeback reported on a hit");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (done_o && !last_o))
    else $error("second lookup without a non-final first result");
`endif

endmodule
